// ===== sv/rv32_subset_execute_unit_macros.svh =====
// Assertion macros for the RV32 subset execute unit.
// Used by the top level only; the macros expect signals named clk and rst_n in scope.
`ifndef RV32_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define RV32_SUBSET_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RV32SE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rv32se: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RV32SE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rv32se: next-cycle check failed");

`endif

// ===== sv/rv32se_pkg.sv =====
// Shared types and constants for the RV32 subset execute unit.
// No dependencies; imported by rv32se_exec, rv32_subset_execute_unit and the bench tb.
`timescale 1ns / 1ps

package rv32se_pkg;

    localparam int unsigned XLEN          = 32;
    localparam int unsigned NUM_REGS      = 32;
    localparam int unsigned REG_AW        = 5;
    localparam int unsigned SHAMT_W       = 5;
    localparam int unsigned MEM_WORDS_DEF = 1024;

    // Major opcodes.
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_JAL    = 7'h6f;

    // funct3 codes.
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;

    // funct7 codes.
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Outcome of executing one instruction, before any load data is known.
    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              illegal;
        logic              wb_en;
        logic              is_load;
        logic [REG_AW-1:0] wb_index;
        logic [XLEN-1:0]   wb_value;
        logic              store_en;
        logic [XLEN-1:0]   store_addr;
        logic [XLEN-1:0]   store_data;
        logic [XLEN-1:0]   mem_addr;
    } exec_res_t;

endpackage

// ===== sv/rv32se_exec.sv =====
// Decode and execute logic for one instruction, purely combinational.
// Depends on rv32se_pkg for opcodes and the result struct.
`timescale 1ns / 1ps

module rv32se_exec
    import rv32se_pkg::*;
(
    input  logic [XLEN-1:0] instr,
    input  logic [XLEN-1:0] pc,
    input  logic [XLEN-1:0] rs1_value,
    input  logic [XLEN-1:0] rs2_value,
    output exec_res_t       res
);

    logic [6:0]        opcode;
    logic [REG_AW-1:0] rd;
    logic [2:0]        funct3;
    logic [6:0]        funct7;
    logic [XLEN-1:0]   imm_i;
    logic [XLEN-1:0]   imm_s;
    logic [XLEN-1:0]   imm_b;
    logic [XLEN-1:0]   imm_j;
    logic [XLEN-1:0]   pc_plus4;
    logic [XLEN-1:0]   addr_sum;
    logic [SHAMT_W-1:0] shamt;
    logic [XLEN-1:0]   sra_value;
    logic              lt_signed;

    assign opcode = instr[6:0];
    assign rd     = instr[11:7];
    assign funct3 = instr[14:12];
    assign funct7 = instr[31:25];

    assign imm_i = {{20{instr[31]}}, instr[31:20]};
    assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

    assign pc_plus4  = pc + XLEN'(4);
    // One adder serves loads, stores, ADDI and the JALR target.
    assign addr_sum  = rs1_value + ((opcode == OP_STORE) ? imm_s : imm_i);
    assign shamt     = rs2_value[SHAMT_W-1:0];
    assign sra_value = $unsigned($signed(rs1_value) >>> shamt);
    assign lt_signed = $signed(rs1_value) < $signed(rs2_value);

    always_comb
    begin
        logic [XLEN-1:0] next;
        logic [XLEN-1:0] val;
        logic            wr;
        logic            st;
        logic            ld;
        logic            bad;
        logic            take;

        next = pc_plus4;
        val  = '0;
        wr   = 1'b0;
        st   = 1'b0;
        ld   = 1'b0;
        bad  = 1'b0;
        take = 1'b0;

        case (opcode)
            OP_LOAD:
            begin
                if (funct3 == F3_WORD)
                begin
                    wr = 1'b1;
                    ld = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            OP_IMM:
            begin
                if (funct3 == F3_ADD)
                begin
                    val = addr_sum;
                    wr  = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            OP_JALR:
            begin
                if (funct3 == F3_ADD)
                begin
                    val  = pc_plus4;
                    wr   = 1'b1;
                    next = {addr_sum[XLEN-1:1], 1'b0};
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            OP_STORE:
            begin
                if (funct3 == F3_WORD)
                begin
                    st = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            OP_REG:
            begin
                wr = 1'b1;
                if (funct3 == F3_ADD && funct7 == F7_BASE)
                    val = rs1_value + rs2_value;
                else if (funct3 == F3_ADD && funct7 == F7_ALT)
                    val = rs1_value - rs2_value;
                else if (funct3 == F3_SLL && funct7 == F7_BASE)
                    val = rs1_value << shamt;
                else if (funct3 == F3_XOR && funct7 == F7_BASE)
                    val = rs1_value ^ rs2_value;
                else if (funct3 == F3_SR && funct7 == F7_ALT)
                    val = sra_value;
                else if (funct3 == F3_OR && funct7 == F7_BASE)
                    val = rs1_value | rs2_value;
                else if (funct3 == F3_AND && funct7 == F7_BASE)
                    val = rs1_value & rs2_value;
                else
                begin
                    bad = 1'b1;
                    wr  = 1'b0;
                end
            end
            OP_LUI:
            begin
                val = {instr[31:12], 12'h000};
                wr  = 1'b1;
            end
            OP_BRANCH:
            begin
                if (funct3 == F3_BEQ)
                    take = (rs1_value == rs2_value);
                else if (funct3 == F3_BNE)
                    take = (rs1_value != rs2_value);
                else if (funct3 == F3_BLT)
                    take = lt_signed;
                else if (funct3 == F3_BGE)
                    take = !lt_signed;
                else
                    bad = 1'b1;
                if (take)
                    next = pc + imm_b;
            end
            OP_JAL:
            begin
                val  = pc_plus4;
                wr   = 1'b1;
                next = pc + imm_j;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase

        // An unimplemented encoding leaves the machine untouched and stays on its pc.
        if (bad)
        begin
            next = pc;
            wr   = 1'b0;
            st   = 1'b0;
            ld   = 1'b0;
        end
        // Writes to x0 are dropped.
        if (rd == '0)
        begin
            wr = 1'b0;
            ld = 1'b0;
        end

        res.next_pc    = next;
        res.illegal    = bad;
        res.wb_en      = wr;
        res.is_load    = ld;
        res.wb_index   = wr ? rd : '0;
        res.wb_value   = wr ? val : '0;
        res.store_en   = st;
        res.store_addr = st ? addr_sum : '0;
        res.store_data = st ? rs2_value : '0;
        res.mem_addr   = addr_sum;
    end

endmodule

// ===== sv/rv32_subset_execute_unit.sv =====
// Top level of the RV32 subset execute unit: pipeline, register file and data memory.
// Depends on rv32se_pkg, rv32se_exec and rv32_subset_execute_unit_macros.svh.
`timescale 1ns / 1ps

// The unit executes one RV32I-subset instruction per beat on the input channel
// (instr, pc, qualified by instr_valid / instr_stall) and returns exactly one result
// beat per instruction on the output channel (next_pc, illegal, write-back and store
// details, qualified by result_valid / result_stall), in program order.
// A beat is taken at a rising edge where valid is high and stall is low.
// The pipeline has three registered stages: operand read at acceptance, execute with
// the data memory access at the end of it, and the result register. One instruction
// can be accepted every cycle once the clearing pass is over and while no stage is held
// by result_stall; back-to-back dependent instructions, including a load followed by a
// use, are resolved by forwarding without bubbles. The rate is therefore one
// instruction per clock under the same conditions, set by the execute stage and the
// one-read-one-write data memory port.
// After reset the register file reads as zero at once (per-register valid bits), and
// the data memory is cleared one word per cycle; instr_stall stays high
// for the whole of that pass.
// When the receiver stalls, the result is held and the earlier stages keep filling
// until every stage is occupied; only then is instr_stall raised.
// MEM_WORDS must be a power of two; the word index is address bits [log2+1:2].

module rv32_subset_execute_unit
    import rv32se_pkg::*;
#(
    parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                instr_valid,
    output logic                instr_stall,
    input  logic [XLEN-1:0]     instr,
    input  logic [XLEN-1:0]     pc,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [XLEN-1:0]     next_pc,
    output logic                illegal,
    output logic                wb_valid,
    output logic [REG_AW-1:0]   wb_index,
    output logic [XLEN-1:0]     wb_value,
    output logic                store_valid,
    output logic [XLEN-1:0]     store_addr,
    output logic [XLEN-1:0]     store_data
);

    `include "rv32_subset_execute_unit_macros.svh"

    localparam int unsigned MEM_AW = $clog2(MEM_WORDS);

    // Storage.
    logic [XLEN-1:0]     rf_reg [NUM_REGS];
    logic [NUM_REGS-1:0] rf_vld_reg;
    logic [XLEN-1:0]     dmem [MEM_WORDS];

    // Clearing pass over the data memory.
    logic              clr_active_reg;
    logic [MEM_AW-1:0] clr_idx_reg;
    logic [MEM_AW-1:0] clr_idx_next;

    // Execute stage.
    logic              x_valid_reg;
    logic [XLEN-1:0]   x_instr_reg;
    logic [XLEN-1:0]   x_pc_reg;
    logic [XLEN-1:0]   rs1_q_reg;
    logic [XLEN-1:0]   rs2_q_reg;
    logic              rs1_vld_reg;
    logic              rs2_vld_reg;

    // Memory stage.
    logic              m_valid_reg;
    exec_res_t         m_res_reg;
    logic [XLEN-1:0]   mem_q_reg;

    // Last register write, covering a read taken on the same edge as that write.
    logic              lw_valid_reg;
    logic [REG_AW-1:0] lw_idx_reg;
    logic [XLEN-1:0]   lw_val_reg;

    // Result register.
    logic              result_valid_reg;
    logic [XLEN-1:0]   next_pc_reg;
    logic              illegal_reg;
    logic              wb_valid_reg;
    logic [REG_AW-1:0] wb_index_reg;
    logic [XLEN-1:0]   wb_value_reg;
    logic              store_valid_reg;
    logic [XLEN-1:0]   store_addr_reg;
    logic [XLEN-1:0]   store_data_reg;

    logic              out_free;
    logic              m_move;
    logic              x_move;
    logic              accept;
    logic [XLEN-1:0]   m_final;
    logic [XLEN-1:0]   rs1_value;
    logic [XLEN-1:0]   rs2_value;
    exec_res_t         x_res;
    logic [MEM_AW-1:0] x_mem_idx;

    // Each stage moves on when the stage after it is empty or moving.
    assign out_free    = !result_valid_reg || !result_stall;
    assign m_move      = m_valid_reg && out_free;
    assign x_move      = x_valid_reg && (!m_valid_reg || m_move);
    assign instr_stall = clr_active_reg || (x_valid_reg && !x_move);
    assign accept      = instr_valid && !instr_stall;

    assign m_final = m_res_reg.is_load ? mem_q_reg : m_res_reg.wb_value;

    // Operand selection: the instruction one stage ahead has not yet written the
    // register file, and the last write may have landed on the edge of the read.
    always_comb
    begin
        logic [REG_AW-1:0] rs1;
        logic [REG_AW-1:0] rs2;

        rs1 = x_instr_reg[19:15];
        rs2 = x_instr_reg[24:20];

        if (rs1 == '0)
            rs1_value = '0;
        else if (m_valid_reg && m_res_reg.wb_en && m_res_reg.wb_index == rs1)
            rs1_value = m_final;
        else if (lw_valid_reg && lw_idx_reg == rs1)
            rs1_value = lw_val_reg;
        else
            rs1_value = rs1_vld_reg ? rs1_q_reg : '0;

        if (rs2 == '0)
            rs2_value = '0;
        else if (m_valid_reg && m_res_reg.wb_en && m_res_reg.wb_index == rs2)
            rs2_value = m_final;
        else if (lw_valid_reg && lw_idx_reg == rs2)
            rs2_value = lw_val_reg;
        else
            rs2_value = rs2_vld_reg ? rs2_q_reg : '0;
    end

    rv32se_exec u_exec
    (
        .instr     (x_instr_reg),
        .pc        (x_pc_reg),
        .rs1_value (rs1_value),
        .rs2_value (rs2_value),
        .res       (x_res)
    );

    assign x_mem_idx    = x_res.mem_addr[MEM_AW+1:2];
    assign clr_idx_next = clr_idx_reg + MEM_AW'(1);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg   <= 1'b1;
            clr_idx_reg      <= '0;
            x_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            lw_valid_reg     <= 1'b0;
            rf_vld_reg       <= '0;
            rs1_vld_reg      <= 1'b0;
            rs2_vld_reg      <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_next;
                if (clr_idx_reg == MEM_AW'(MEM_WORDS - 1))
                    clr_active_reg <= 1'b0;
            end

            if (accept)
                x_valid_reg <= 1'b1;
            else if (x_move)
                x_valid_reg <= 1'b0;

            if (x_move)
                m_valid_reg <= 1'b1;
            else if (m_move)
                m_valid_reg <= 1'b0;

            if (m_move)
                result_valid_reg <= 1'b1;
            else if (out_free)
                result_valid_reg <= 1'b0;

            if (m_move && m_res_reg.wb_en)
            begin
                lw_valid_reg                      <= 1'b1;
                rf_vld_reg[m_res_reg.wb_index]    <= 1'b1;
            end

            if (accept)
            begin
                rs1_vld_reg <= rf_vld_reg[instr[19:15]];
                rs2_vld_reg <= rf_vld_reg[instr[24:20]];
            end
        end
    end

    // Register file: two registered reads at acceptance, one write from the memory stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rs1_q_reg <= rf_reg[instr[19:15]];
            rs2_q_reg <= rf_reg[instr[24:20]];
        end
        if (m_move && m_res_reg.wb_en)
            rf_reg[m_res_reg.wb_index] <= m_final;
    end

    // Data memory: the clearing pass or a store writes, a load reads into mem_q_reg.
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            dmem[clr_idx_reg] <= '0;
        else if (x_move && x_res.store_en)
            dmem[x_mem_idx] <= x_res.store_data;
        if (x_move && x_res.is_load)
            mem_q_reg <= dmem[x_mem_idx];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_instr_reg <= instr;
            x_pc_reg    <= pc;
        end
        if (x_move)
            m_res_reg <= x_res;
        if (m_move && m_res_reg.wb_en)
        begin
            lw_idx_reg <= m_res_reg.wb_index;
            lw_val_reg <= m_final;
        end
        if (m_move)
        begin
            next_pc_reg     <= m_res_reg.next_pc;
            illegal_reg     <= m_res_reg.illegal;
            wb_valid_reg    <= m_res_reg.wb_en;
            wb_index_reg    <= m_res_reg.wb_index;
            wb_value_reg    <= m_final;
            store_valid_reg <= m_res_reg.store_en;
            store_addr_reg  <= m_res_reg.store_addr;
            store_data_reg  <= m_res_reg.store_data;
        end
    end

    assign result_valid = result_valid_reg;
    assign next_pc      = next_pc_reg;
    assign illegal      = illegal_reg;
    assign wb_valid     = wb_valid_reg;
    assign wb_index     = wb_index_reg;
    assign wb_value     = wb_value_reg;
    assign store_valid  = store_valid_reg;
    assign store_addr   = store_addr_reg;
    assign store_data   = store_data_reg;

    // The pipeline stays empty for the whole clearing pass.
    `RV32SE_ASSERT_IMP(a_empty_while_clearing, clr_active_reg,
        !x_valid_reg && !m_valid_reg && !result_valid_reg)
    // An illegal instruction neither writes a register nor stores.
    `RV32SE_ASSERT_IMP(a_illegal_no_effect, result_valid_reg && illegal_reg,
        !wb_valid_reg && !store_valid_reg)
    // A reported write-back never targets x0.
    `RV32SE_ASSERT_IMP(a_no_x0_write, result_valid_reg && wb_valid_reg, wb_index_reg != '0)
    // A taken result with nothing behind it leaves the output empty.
    `RV32SE_ASSERT_NXT(a_drain, result_valid_reg && !result_stall && !m_valid_reg,
        !result_valid_reg)

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for rv32_subset_execute_unit: directed and random RV32I-subset
// instructions go in, and every result beat is compared with a predicted outcome.
// Depends on rv32se_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;
    import rv32se_pkg::*;

    // The limit leaves a wide margin over the slowest correct run, including the
    // memory clearing pass after reset.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_PER_PHASE = 317;
    localparam int unsigned DRAIN_CYCLES = 16;

    // One instruction waiting to be sent: the word and its byte address.
    typedef struct packed {
        logic [XLEN-1:0] word;
        logic [XLEN-1:0] at;
    } fetch_t;

    // Everything one result beat carries.
    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              illegal;
        logic              wb_valid;
        logic [REG_AW-1:0] wb_index;
        logic [XLEN-1:0]   wb_value;
        logic              store_valid;
        logic [XLEN-1:0]   store_addr;
        logic [XLEN-1:0]   store_data;
    } outcome_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              instr_valid = 1'b0;
    logic              instr_stall;
    logic [XLEN-1:0]   instr = '0;
    logic [XLEN-1:0]   pc = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [XLEN-1:0]   next_pc;
    logic              illegal;
    logic              wb_valid;
    logic [REG_AW-1:0] wb_index;
    logic [XLEN-1:0]   wb_value;
    logic              store_valid;
    logic [XLEN-1:0]   store_addr;
    logic [XLEN-1:0]   store_data;

    // Architectural state as the bench sees it. x0 is never written, so it stays zero.
    logic [XLEN-1:0] gpr [NUM_REGS];
    logic [XLEN-1:0] dmem [MEM_WORDS_DEF];

    fetch_t   program_q[$];
    outcome_t retire_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    rv32_subset_execute_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instr        (instr),
        .pc           (pc),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .next_pc      (next_pc),
        .illegal      (illegal),
        .wb_valid     (wb_valid),
        .wb_index     (wb_index),
        .wb_value     (wb_value),
        .store_valid  (store_valid),
        .store_addr   (store_addr),
        .store_data   (store_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Instruction encoders, one per format.
    // ------------------------------------------------------------------
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
        return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd);
        return {imm, rd, OP_LUI};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // ------------------------------------------------------------------
    // Prediction. Only the low bits of the word address select a memory word.
    // ------------------------------------------------------------------
    function automatic int unsigned word_index(logic [31:0] addr);
        return (addr >> 2) % MEM_WORDS_DEF;
    endfunction

    // Executes one instruction against the bench's copy of the state, updates that
    // state and returns what the result beat should carry.
    function automatic outcome_t execute_insn(logic [31:0] ins, logic [31:0] at_pc);
        outcome_t    o;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic [31:0] val;
        logic        wr;
        logic        bad;
        logic        take;
        rd = ins[11:7];
        f3 = ins[14:12];
        f7 = ins[31:25];
        a = gpr[ins[19:15]];
        b = gpr[ins[24:20]];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        o = '0;
        o.next_pc = at_pc + 32'd4;
        val = '0;
        wr = 1'b0;
        bad = 1'b0;
        take = 1'b0;
        case (ins[6:0])
            OP_LOAD:
            begin
                if (f3 == F3_WORD)
                begin
                    val = dmem[word_index(a + imm_i)];
                    wr = 1'b1;
                end
                else
                    bad = 1'b1;
            end
            OP_IMM:
            begin
                if (f3 == F3_ADD)
                begin
                    val = a + imm_i;
                    wr = 1'b1;
                end
                else
                    bad = 1'b1;
            end
            OP_JALR:
            begin
                if (f3 == F3_ADD)
                begin
                    val = at_pc + 32'd4;
                    wr = 1'b1;
                    o.next_pc = (a + imm_i) & ~32'd1;
                end
                else
                    bad = 1'b1;
            end
            OP_STORE:
            begin
                if (f3 == F3_WORD)
                begin
                    o.store_valid = 1'b1;
                    o.store_addr = a + imm_s;
                    o.store_data = b;
                end
                else
                    bad = 1'b1;
            end
            OP_REG:
            begin
                wr = 1'b1;
                if (f3 == F3_ADD && f7 == F7_BASE)
                    val = a + b;
                else if (f3 == F3_ADD && f7 == F7_ALT)
                    val = a - b;
                else if (f3 == F3_SLL && f7 == F7_BASE)
                    val = a << b[4:0];
                else if (f3 == F3_XOR && f7 == F7_BASE)
                    val = a ^ b;
                else if (f3 == F3_SR && f7 == F7_ALT)
                    val = $signed(a) >>> b[4:0];
                else if (f3 == F3_OR && f7 == F7_BASE)
                    val = a | b;
                else if (f3 == F3_AND && f7 == F7_BASE)
                    val = a & b;
                else
                begin
                    bad = 1'b1;
                    wr = 1'b0;
                end
            end
            OP_LUI:
            begin
                val = {ins[31:12], 12'h000};
                wr = 1'b1;
            end
            OP_BRANCH:
            begin
                case (f3)
                    F3_BEQ: take = (a == b);
                    F3_BNE: take = (a != b);
                    F3_BLT: take = ($signed(a) < $signed(b));
                    F3_BGE: take = !($signed(a) < $signed(b));
                    default: bad = 1'b1;
                endcase
                if (take)
                    o.next_pc = at_pc + imm_b;
            end
            OP_JAL:
            begin
                val = at_pc + 32'd4;
                wr = 1'b1;
                o.next_pc = at_pc + imm_j;
            end
            default:
                bad = 1'b1;
        endcase
        // An unimplemented encoding leaves everything untouched and stays at pc.
        if (bad)
        begin
            o = '0;
            o.next_pc = at_pc;
            o.illegal = 1'b1;
            wr = 1'b0;
        end
        // Writes to x0 are dropped and leave the write-back fields at zero.
        if (wr && rd != 5'd0)
        begin
            gpr[rd] = val;
            o.wb_valid = 1'b1;
            o.wb_index = rd;
            o.wb_value = val;
        end
        if (o.store_valid)
            dmem[word_index(o.store_addr)] = o.store_data;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Random instruction generation.
    // ------------------------------------------------------------------

    // Mostly low registers, so that results are read back soon after they are written.
    function automatic logic [4:0] pick_reg();
        logic [31:0] r;
        r = $urandom();
        if ($urandom_range(0, 9) < 8)
            return {2'b00, r[2:0]};
        return r[4:0];
    endfunction

    function automatic logic [11:0] pick_imm();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 7))
            0: return 12'h000;
            1: return 12'hFFF;
            2: return 12'h7FF;
            3: return 12'h800;
            default: return r[11:0];
        endcase
    endfunction

    function automatic logic [31:0] random_insn();
        logic [31:0] w;
        logic [31:0] r;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [11:0] imm;
        logic [11:0] mem_off;
        int unsigned pick;
        w = $urandom();
        r = $urandom();
        rd = pick_reg();
        rs1 = pick_reg();
        rs2 = pick_reg();
        imm = pick_imm();
        pick = $urandom_range(0, 99);
        // A small share is pure noise, another small share a known opcode with
        // random funct fields, which is mostly illegal.
        if (pick < 6)
            return w;
        if (pick < 12)
        begin
            case ($urandom_range(0, 7))
                0: w[6:0] = OP_REG;
                1: w[6:0] = OP_LOAD;
                2: w[6:0] = OP_IMM;
                3: w[6:0] = OP_JALR;
                4: w[6:0] = OP_STORE;
                5: w[6:0] = OP_BRANCH;
                6: w[6:0] = OP_LUI;
                default: w[6:0] = OP_JAL;
            endcase
            return w;
        end
        // Loads and stores mostly address a small window off x0, so that loads find
        // data that earlier stores left behind; the low two address bits vary too.
        mem_off = {5'd0, r[6:0]};
        if ($urandom_range(0, 9) < 6)
        begin
            rs1 = 5'd0;
            imm = mem_off;
        end
        case ($urandom_range(0, 16))
            0: return enc_i(imm, rs1, F3_WORD, rd, OP_LOAD);
            1: return enc_s(imm, rs2, rs1);
            2: return enc_i(pick_imm(), pick_reg(), F3_ADD, rd, OP_IMM);
            3: return enc_i(pick_imm(), pick_reg(), F3_ADD, rd, OP_JALR);
            4: return enc_r(F7_BASE, rs2, rs1, F3_ADD, rd);
            5: return enc_r(F7_ALT, rs2, rs1, F3_ADD, rd);
            6: return enc_r(F7_BASE, rs2, rs1, F3_SLL, rd);
            7: return enc_r(F7_BASE, rs2, rs1, F3_XOR, rd);
            8: return enc_r(F7_ALT, rs2, rs1, F3_SR, rd);
            9: return enc_r(F7_BASE, rs2, rs1, F3_OR, rd);
            10: return enc_r(F7_BASE, rs2, rs1, F3_AND, rd);
            11: return enc_u(w[31:12], rd);
            12, 13, 14, 15:
            begin
                // Equal operands now and then, so that equality branches are taken.
                if ($urandom_range(0, 2) == 0)
                    rs2 = rs1;
                case (pick % 4)
                    0: return enc_b({w[31:20], 1'b0}, rs2, rs1, F3_BEQ);
                    1: return enc_b({w[31:20], 1'b0}, rs2, rs1, F3_BNE);
                    2: return enc_b({w[31:20], 1'b0}, rs2, rs1, F3_BLT);
                    default: return enc_b({w[31:20], 1'b0}, rs2, rs1, F3_BGE);
                endcase
            end
            default: return enc_j({w[31:12], 1'b0}, rd);
        endcase
    endfunction

    task automatic add_insn(input logic [31:0] word, input logic [31:0] at);
        program_q.push_back('{word: word, at: at});
    endtask

    // ------------------------------------------------------------------
    // Error reporting: one line per problem, and a running count.
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s is %08h, predicted %08h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver. The front of program_q is the beat on offer; it leaves the queue when
    // the unit takes it, and its outcome is predicted at that same edge. A new beat
    // (or an idle cycle) is chosen only when nothing is being held on the channel,
    // so a stalled beat never changes and valid never looks at stall.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (instr_valid && !instr_stall)
            begin
                retire_q.push_back(execute_insn(instr, pc));
                program_q.delete(0);
            end
            if (!instr_valid || !instr_stall)
            begin
                if (program_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    instr_valid <= 1'b1;
                    instr <= program_q[0].word;
                    pc <= program_q[0].at;
                end
                else
                    instr_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. The stall seen here is the one driven at the previous edge, so the
    // acceptance test uses the same values as the unit does.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        outcome_t want;
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        if (rst_n && result_valid && !result_stall)
        begin
            if (retire_q.size() == 0)
                flag_error($sformatf("result beat with next_pc %08h and nothing predicted",
                                     next_pc));
            else
            begin
                want = retire_q.pop_front();
                compare_field("next_pc", next_pc, want.next_pc);
                compare_field("illegal", {31'd0, illegal}, {31'd0, want.illegal});
                compare_field("wb_valid", {31'd0, wb_valid}, {31'd0, want.wb_valid});
                compare_field("wb_index", {27'd0, wb_index}, {27'd0, want.wb_index});
                compare_field("wb_value", wb_value, want.wb_value);
                compare_field("store_valid", {31'd0, store_valid}, {31'd0, want.store_valid});
                compare_field("store_addr", store_addr, want.store_addr);
                compare_field("store_data", store_data, want.store_data);
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. Three phases: a slow receiver, then a slow sender, then full rate.
    // The directed program opens the first phase: it builds extreme operand values,
    // runs every operation on them, then covers memory wrap and ignored address
    // bits, x0, the JALR bit-0 clear with pc wrap, the jump and branch extremes and
    // two unimplemented encodings.
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < NUM_REGS; i++)
            gpr[i] = '0;
        for (int i = 0; i < MEM_WORDS_DEF; i++)
            dmem[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 24;
                    recv_stall_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_stall_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                add_insn(enc_u(20'h80000, 5'd1), 32'h0000_0000);
                add_insn(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM), 32'h0000_0004);
                add_insn(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, OP_IMM), 32'h0000_0008);
                add_insn(enc_i(12'h800, 5'd0, F3_ADD, 5'd4, OP_IMM), 32'h0000_000C);
                add_insn(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd5), 32'h0000_0010);
                add_insn(enc_r(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd6), 32'h0000_0014);
                add_insn(enc_r(F7_BASE, 5'd3, 5'd2, F3_SLL, 5'd7), 32'h0000_0018);
                add_insn(enc_r(F7_BASE, 5'd2, 5'd1, F3_XOR, 5'd8), 32'h0000_001C);
                add_insn(enc_r(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd9), 32'h0000_0020);
                add_insn(enc_r(F7_ALT, 5'd0, 5'd1, F3_SR, 5'd10), 32'h0000_0024);
                add_insn(enc_r(F7_BASE, 5'd4, 5'd3, F3_OR, 5'd11), 32'h0000_0028);
                add_insn(enc_r(F7_BASE, 5'd1, 5'd2, F3_AND, 5'd12), 32'h0000_002C);
                // Address 0xFFFFFFFC wraps to the last memory word.
                add_insn(enc_s(12'hFFC, 5'd2, 5'd0), 32'h0000_0030);
                add_insn(enc_i(12'hFFC, 5'd0, F3_WORD, 5'd13, OP_LOAD), 32'h0000_0034);
                // Same word again with both low address bits set.
                add_insn(enc_i(12'hFFF, 5'd0, F3_WORD, 5'd14, OP_LOAD), 32'h0000_0038);
                add_insn(enc_i(12'h001, 5'd2, F3_ADD, 5'd0, OP_IMM), 32'h0000_003C);
                // Target 0xFFFFFFFF loses bit 0; the link value wraps to zero.
                add_insn(enc_i(12'h000, 5'd2, F3_ADD, 5'd17, OP_JALR), 32'hFFFF_FFFC);
                add_insn(enc_j(21'h100000, 5'd18), 32'h0000_0000);
                add_insn(enc_j(21'h0FFFFE, 5'd0), 32'h7FFF_FFFC);
                add_insn(enc_b(13'h1000, 5'd2, 5'd2, F3_BEQ), 32'h0000_0000);
                add_insn(enc_b(13'h0FFE, 5'd1, 5'd1, F3_BNE), 32'h0000_0040);
                add_insn(enc_b(13'h0008, 5'd3, 5'd1, F3_BLT), 32'h0000_0044);
                add_insn(enc_b(13'h0008, 5'd3, 5'd1, F3_BGE), 32'h0000_0048);
                add_insn(32'hFFFF_FFFF, 32'h0000_004C);
                // A branch with a word-size funct3 has no meaning.
                add_insn(enc_b(13'h0008, 5'd1, 5'd1, F3_WORD), 32'h0000_0050);
            end

            repeat (RANDOM_PER_PHASE)
                add_insn(random_insn(), $urandom());

            while (program_q.size() != 0 || retire_q.size() != 0)
                @(posedge clk);
        end

        // Nothing should follow the last result; give stray beats a chance to show.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
